/* src/arpc_pkg.sv */
// Package for the ARP cache with aging: payload types, codes and field constants.
// No dependencies.
`default_nettype none
package arpc_pkg;

	localparam logic [15:0] HW_TYPE_ETH  = 16'h0001;
	localparam logic [15:0] PROTO_IPV4   = 16'h0800;
	localparam logic [7:0]  HW_LEN_ETH   = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IP = 8'd4;
	localparam logic [15:0] OP_REQUEST   = 16'd1;
	localparam logic [15:0] OP_REPLY     = 16'd2;
	localparam logic [47:0] MAC_BCAST    = {48{1'b1}};

	localparam logic [2:0] CFG_MY_IP         = 3'd0;
	localparam logic [2:0] CFG_MY_MAC        = 3'd1;
	localparam logic [2:0] CFG_VALID_TICKS   = 3'd2;
	localparam logic [2:0] CFG_PENDING_TICKS = 3'd3;
	localparam logic [2:0] CFG_RETRY_LIMIT   = 3'd4;

	typedef enum logic [2:0] {
		ACT_IDLE    = 3'd0,
		ACT_REPLY   = 3'd1,
		ACT_REQUEST = 3'd2,
		ACT_REJECT  = 3'd3,
		ACT_LEARN   = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_SHORT  = 2'd1,
		STS_FORMAT = 2'd2,
		STS_NOTUS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ENT_FREE    = 2'd0,
		ENT_BUSY    = 2'd1,
		ENT_PENDING = 2'd2,
		ENT_UNUSED  = 2'd3
	} entry_st_t;

	typedef struct packed {
		logic        mode;
		logic        frame_short;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] opcode;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] target_ip;
	} arp_in_t;

	typedef struct packed {
		action_t     action;
		status_t     status;
		logic [31:0] dest_ip;
		logic [47:0] dest_mac;
		logic        last;
	} arp_out_t;

endpackage
`default_nettype wire

/* src/arp_cache_with_aging_top.sv */
// ARP cache with aging, top level: sequencer walking the entry table with one
// shared compare and one shared decrement unit. Depends on arpc_pkg.
//
// Usage: drive a word on in with start high; it is taken when busy is low.
// busy falls once the item's final result word (last set) is out; for a tick
// that word shows in the first cycle after busy falls.
// Each result sits on out for one cycle with out_valid high; the receiver
// cannot stall, so results leave at once.
// Config: cfg_we, cfg_addr and cfg_data write one register per cycle; write
// only while busy is low.
// Flow: a rejected packet ends after the checks. An accepted packet scans the
// table for a matching IP, one entry per cycle; a request's reply word leaves
// right after the checks, the learned word at the end. A tick walks every
// entry once, one entry per cycle through the shared decrementer; each request
// word is held back until the next one is found so the final one can carry
// last, and the final word (request or idle) leaves after the walk.
// Reset clears all entries to free, the victim pointer to zero and the
// registers to their defaults; no clearing pass is needed.
`default_nettype none
module arp_cache_with_aging_top
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire arp_in_t     in,
	output      logic        out_valid,
	output      arp_out_t    out,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [47:0] cfg_data
);
	localparam int IW = $clog2(TABLE_ENTRIES);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CHECK = 6'b000010,
		S_SCAN  = 6'b000100,
		S_WRITE = 6'b001000,
		S_AGE   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	arp_in_t in_q;
	logic [31:0] my_ip_q;
	logic [47:0] my_mac_q;
	logic [15:0] valid_ticks_q, pending_ticks_q;
	logic [3:0]  retry_limit_q;
	entry_st_t   st_q [TABLE_ENTRIES];
	logic [31:0] ip_q [TABLE_ENTRIES];
	logic [47:0] mac_q [TABLE_ENTRIES];
	logic [15:0] tmr_q [TABLE_ENTRIES];
	logic [3:0]  rty_q [TABLE_ENTRIES];
	logic [IW-1:0] vic_q, idx_q, slot_q;
	logic found_q, any_q;
	logic [31:0] hold_ip_q;

	logic [15:0] tmr_dec;
	logic [3:0]  rty_dec;
	logic hit, scan_end, age_req;
	entry_st_t cur_st;

	assign cur_st   = st_q[idx_q];
	assign tmr_dec  = tmr_q[idx_q] - 16'd1;
	assign rty_dec  = rty_q[idx_q] - 4'd1;
	assign hit      = (cur_st == ENT_BUSY || cur_st == ENT_PENDING) &&
		ip_q[idx_q] == in_q.sender_ip;
	assign scan_end = idx_q == IW'(TABLE_ENTRIES - 1);
	assign age_req  = tmr_dec == 16'd0 &&
		(cur_st == ENT_BUSY || (cur_st == ENT_PENDING && rty_dec != 4'd0));
	assign busy     = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_ip_q <= '0;
			my_mac_q <= '0;
			valid_ticks_q <= 16'd1200;
			pending_ticks_q <= 16'd3;
			retry_limit_q <= 4'd5;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_MY_IP:         my_ip_q <= cfg_data[31:0];
				CFG_MY_MAC:        my_mac_q <= cfg_data;
				CFG_VALID_TICKS:   valid_ticks_q <= cfg_data[15:0];
				CFG_PENDING_TICKS: pending_ticks_q <= cfg_data[15:0];
				CFG_RETRY_LIMIT:   retry_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start)
			in_q <= in;
		if (state_q == S_WRITE) begin
			ip_q[slot_q] <= in_q.sender_ip;
			mac_q[slot_q] <= in_q.sender_mac;
			tmr_q[slot_q] <= valid_ticks_q;
			rty_q[slot_q] <= retry_limit_q;
		end
		if (state_q == S_AGE) begin
			if (cur_st == ENT_BUSY) begin
				tmr_q[idx_q] <= (tmr_dec == 16'd0) ? pending_ticks_q : tmr_dec;
				if (tmr_dec == 16'd0)
					rty_q[idx_q] <= retry_limit_q;
			end else if (cur_st == ENT_PENDING) begin
				tmr_q[idx_q] <= (tmr_dec == 16'd0 && rty_dec != 4'd0) ?
					pending_ticks_q : tmr_dec;
				if (tmr_dec == 16'd0)
					rty_q[idx_q] <= rty_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				st_q[i] <= ENT_FREE;
			vic_q <= '0;
			idx_q <= '0;
			slot_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
			hold_ip_q <= '0;
			out_valid <= 1'b0;
			out <= '0;
		end else begin
			out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					found_q <= 1'b0;
					any_q <= 1'b0;
					if (start)
						state_q <= in.mode ? S_CHECK : S_AGE;
				end
				S_CHECK: begin
					out.dest_ip <= '0;
					out.dest_mac <= '0;
					out.action <= ACT_REJECT;
					out.last <= 1'b1;
					if (in_q.frame_short) begin
						out.status <= STS_SHORT;
						out_valid <= 1'b1;
						state_q <= S_DONE;
					end else if (in_q.hw_type != HW_TYPE_ETH || in_q.proto_type != PROTO_IPV4 ||
						in_q.hw_len != HW_LEN_ETH || in_q.proto_len != PROTO_LEN_IP ||
						(in_q.opcode != OP_REQUEST && in_q.opcode != OP_REPLY)) begin
						out.status <= STS_FORMAT;
						out_valid <= 1'b1;
						state_q <= S_DONE;
					end else if (in_q.target_ip != my_ip_q) begin
						out.status <= STS_NOTUS;
						out_valid <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
						if (in_q.opcode == OP_REQUEST) begin
							out.action <= ACT_REPLY;
							out.status <= STS_OK;
							out.dest_ip <= in_q.sender_ip;
							out.dest_mac <= in_q.sender_mac;
							out.last <= 1'b0;
							out_valid <= 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
						slot_q <= idx_q;
					end
					if (scan_end) begin
						state_q <= S_WRITE;
						if (!(found_q || hit)) begin
							slot_q <= vic_q;
							vic_q <= (vic_q == IW'(TABLE_ENTRIES - 1)) ? '0 : vic_q + 1'b1;
						end
					end else
						idx_q <= idx_q + 1'b1;
				end
				S_WRITE: begin
					st_q[slot_q] <= ENT_BUSY;
					out.action <= ACT_LEARN;
					out.status <= STS_OK;
					out.dest_ip <= in_q.sender_ip;
					out.dest_mac <= in_q.sender_mac;
					out.last <= 1'b1;
					out_valid <= 1'b1;
					state_q <= S_DONE;
				end
				S_AGE: begin
					if (cur_st == ENT_BUSY && tmr_dec == 16'd0)
						st_q[idx_q] <= ENT_PENDING;
					else if (cur_st == ENT_PENDING && tmr_dec == 16'd0 && rty_dec == 4'd0)
						st_q[idx_q] <= ENT_FREE;
					if (age_req) begin
						if (any_q) begin
							out.action <= ACT_REQUEST;
							out.status <= STS_OK;
							out.dest_ip <= hold_ip_q;
							out.dest_mac <= MAC_BCAST;
							out.last <= 1'b0;
							out_valid <= 1'b1;
						end
						hold_ip_q <= ip_q[idx_q];
						any_q <= 1'b1;
					end
					if (scan_end)
						state_q <= S_DONE;
					else
						idx_q <= idx_q + 1'b1;
				end
				S_DONE: begin
					// tick tail: held final request or the idle word
					if (!in_q.mode) begin
						out.action <= any_q ? ACT_REQUEST : ACT_IDLE;
						out.status <= STS_OK;
						out.dest_ip <= any_q ? hold_ip_q : '0;
						out.dest_mac <= any_q ? MAC_BCAST : '0;
						out.last <= 1'b1;
						out_valid <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/arpc_checker.sv */
// Port-level checker for the ARP cache, bound to the top level.
// Depends on arpc_pkg.
`default_nettype none
module arpc_checker
	import arpc_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     start,
	input wire logic     busy,
	input wire logic     out_valid,
	input wire arp_out_t out
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_out_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy || $past(busy)) else $error("word outside item");
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out.action == ACT_REJECT |-> out.last) else $error("reject not last");
	a_reply_then_learn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out.action == ACT_REPLY |-> !out.last) else $error("reply marked last");
endmodule

bind arp_cache_with_aging_top arpc_checker u_arpc_checker (.*);
`default_nettype wire

/* verif/tb.sv */
// Testbench for arp_cache_with_aging_top: packet and tick words against a table predictor.
// Driver and monitor run as clocked blocks; depends on arpc_pkg and the top level.
`default_nettype none
module tb;
	import arpc_pkg::*;

	localparam int N_ENT = 8;
	localparam int LIMIT = 2000000;
	localparam int IN_W = $bits(arp_in_t);

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	arp_in_t in_word;
	logic out_valid;
	arp_out_t out_word;
	logic cfg_we;
	logic [2:0] cfg_addr;
	logic [47:0] cfg_data;

	arp_cache_with_aging_top #(.TABLE_ENTRIES(N_ENT)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in(in_word),
		.out_valid(out_valid), .out(out_word), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] p_my_ip;
	logic [15:0] p_valid_ticks, p_pending_ticks;
	logic [3:0] p_retry_limit;
	entry_st_t t_st[N_ENT];
	logic [31:0] t_ip[N_ENT];
	logic [47:0] t_mac[N_ENT];
	logic [15:0] t_timer[N_ENT];
	logic [3:0] t_retry[N_ENT];
	logic [2:0] victim;

	arp_in_t pending_words[$];
	arp_out_t expected_words[$];
	int errors = 0;
	int cycles = 0;
	int gap = 0;
	logic sent;
	logic [31:0] ip_pool[4];

	task automatic report(input string what);
		errors++;
		$display("tb: mismatch %s at cycle %0d", what, cycles);
	endtask

	function automatic arp_out_t mk(input action_t a, input status_t s, input logic [31:0] ip,
			input logic [47:0] mac, input logic l);
		arp_out_t r;
		r.action = a; r.status = s; r.dest_ip = ip; r.dest_mac = mac; r.last = l;
		return r;
	endfunction

	task automatic learn_entry(input logic [31:0] ip, input logic [47:0] mac);
		int slot;
		slot = -1;
		for (int i = 0; i < N_ENT; i++)
			if (slot < 0 && (t_st[i] == ENT_BUSY || t_st[i] == ENT_PENDING) && t_ip[i] == ip)
				slot = i;
		if (slot < 0) begin
			slot = int'(victim);
			victim = victim + 3'd1;
		end
		t_ip[slot] = ip; t_mac[slot] = mac; t_st[slot] = ENT_BUSY;
		t_timer[slot] = p_valid_ticks; t_retry[slot] = p_retry_limit;
	endtask

	task automatic predict_word(input arp_in_t w);
		int n;
		n = 0;
		if (!w.mode) begin
			for (int i = 0; i < N_ENT; i++) begin
				if (t_st[i] == ENT_BUSY) begin
					t_timer[i] = t_timer[i] - 16'd1;
					if (t_timer[i] == 16'd0) begin
						expected_words.push_back(mk(ACT_REQUEST, STS_OK, t_ip[i], MAC_BCAST, 1'b0));
						n++;
						t_st[i] = ENT_PENDING; t_timer[i] = p_pending_ticks;
						t_retry[i] = p_retry_limit;
					end
				end else if (t_st[i] == ENT_PENDING) begin
					t_timer[i] = t_timer[i] - 16'd1;
					if (t_timer[i] == 16'd0) begin
						t_retry[i] = t_retry[i] - 4'd1;
						if (t_retry[i] == 4'd0) t_st[i] = ENT_FREE;
						else begin
							expected_words.push_back(mk(ACT_REQUEST, STS_OK, t_ip[i], MAC_BCAST, 1'b0));
							n++;
							t_timer[i] = p_pending_ticks;
						end
					end
				end
			end
			if (n == 0) expected_words.push_back(mk(ACT_IDLE, STS_OK, '0, '0, 1'b1));
			else expected_words[$].last = 1'b1;
		end else if (w.frame_short) begin
			expected_words.push_back(mk(ACT_REJECT, STS_SHORT, '0, '0, 1'b1));
		end else if (w.hw_type != HW_TYPE_ETH || w.proto_type != PROTO_IPV4 ||
				w.hw_len != HW_LEN_ETH || w.proto_len != PROTO_LEN_IP ||
				(w.opcode != OP_REQUEST && w.opcode != OP_REPLY)) begin
			expected_words.push_back(mk(ACT_REJECT, STS_FORMAT, '0, '0, 1'b1));
		end else if (w.target_ip != p_my_ip) begin
			expected_words.push_back(mk(ACT_REJECT, STS_NOTUS, '0, '0, 1'b1));
		end else begin
			learn_entry(w.sender_ip, w.sender_mac);
			if (w.opcode == OP_REQUEST)
				expected_words.push_back(mk(ACT_REPLY, STS_OK, w.sender_ip, w.sender_mac, 1'b0));
			expected_words.push_back(mk(ACT_LEARN, STS_OK, w.sender_ip, w.sender_mac, 1'b1));
		end
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	function automatic arp_in_t good_pkt(input logic [31:0] sip, input logic [15:0] op);
		arp_in_t w;
		w.mode = 1'b1; w.frame_short = 1'b0; w.hw_type = HW_TYPE_ETH; w.proto_type = PROTO_IPV4;
		w.hw_len = HW_LEN_ETH; w.proto_len = PROTO_LEN_IP; w.opcode = op;
		w.sender_ip = sip; w.sender_mac = 48'({$urandom, $urandom});
		w.target_ip = p_my_ip;
		return w;
	endfunction

	function automatic arp_in_t tick_word();
		arp_in_t w;
		w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		w.mode = 1'b0;
		return w;
	endfunction

	function automatic arp_in_t rand_pkt();
		arp_in_t w;
		int k;
		k = $urandom_range(0, 9);
		w = good_pkt(ip_pool[$urandom_range(0, 3)], 16'($urandom_range(1, 2)));
		if ($urandom_range(0, 3) == 0) w.sender_ip = $urandom;
		case (k)
			0: w.frame_short = 1'b1;
			1: w.hw_type = 16'($urandom);
			2: w.proto_type = 16'($urandom);
			3: w.hw_len = 8'($urandom);
			4: w.proto_len = 8'($urandom);
			5: w.opcode = 16'($urandom);
			6: w.target_ip = $urandom;
			7: w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			default: ;
		endcase
		w.mode = 1'b1;
		return w;
	endfunction

	task automatic cfg_write(input logic [2:0] a, input logic [47:0] d);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_addr <= a; cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (a)
			CFG_MY_IP: p_my_ip = d[31:0];
			CFG_VALID_TICKS: p_valid_ticks = d[15:0];
			CFG_PENDING_TICKS: p_pending_ticks = d[15:0];
			CFG_RETRY_LIMIT: p_retry_limit = d[3:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || expected_words.size() != 0 || busy || start)
			@(posedge clk);
		repeat (2 * N_ENT + 6) @(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap = 0;
		end else begin
			sent = start && !busy;
			if (sent) predict_word(in_word);
			if (start && !sent) begin
			end else if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (pending_words.size() != 0) begin
				in_word <= pending_words.pop_front();
				start <= 1'b1;
				gap = pick_gap();
			end else
				start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (expected_words.size() == 0)
				report("unexpected word");
			else begin
				arp_out_t e;
				e = expected_words.pop_front();
				if (out_word.action !== e.action) report("action");
				if (out_word.status !== e.status) report("status");
				if (out_word.dest_ip !== e.dest_ip) report("dest_ip");
				if (out_word.dest_mac !== e.dest_mac) report("dest_mac");
				if (out_word.last !== e.last) report("last");
			end
		end
	end

	initial begin
		arp_in_t w;
		arst_n = 1'b0; start = 1'b0; in_word = '0; cfg_we = 1'b0; cfg_addr = CFG_MY_IP;
		cfg_data = '0;
		p_my_ip = '0; p_valid_ticks = 16'd1200; p_pending_ticks = 16'd3; p_retry_limit = 4'd5;
		victim = '0;
		for (int i = 0; i < N_ENT; i++) begin
			t_st[i] = ENT_FREE; t_ip[i] = '0; t_mac[i] = '0; t_timer[i] = '0; t_retry[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: defaults, then short timers
		pending_words.push_back(tick_word());
		pending_words.push_back(good_pkt(32'h0, OP_REQUEST));
		w = good_pkt(32'hFFFFFFFF, OP_REPLY); w.sender_mac = 48'hFFFFFFFFFFFF;
		pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.frame_short = 1'b1; w.hw_type = '0;
		pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.hw_type = 16'hFFFF; pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.proto_type = '0; pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.hw_len = 8'hFF; pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.proto_len = '0; pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.opcode = 16'hFFFF; pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.opcode = '0; pending_words.push_back(w);
		w = good_pkt(32'h1, OP_REPLY); w.target_ip = 32'hFFFFFFFF; pending_words.push_back(w);
		drain();
		cfg_write(CFG_MY_IP, 48'hFFFFFFFFFFFF);
		cfg_write(CFG_MY_MAC, 48'hFFFFFFFFFFFF);
		cfg_write(CFG_VALID_TICKS, 48'd1);
		cfg_write(CFG_PENDING_TICKS, 48'd1);
		cfg_write(CFG_RETRY_LIMIT, 48'd1);
		for (int i = 0; i < 10; i++)
			pending_words.push_back(good_pkt(32'h100 + 32'(i), OP_REQUEST));
		pending_words.push_back(good_pkt(32'h101, OP_REPLY));
		repeat (3) pending_words.push_back(tick_word());
		drain();

		// random phases
		for (int ph = 0; ph < 9; ph++) begin
			case (ph % 4)
				0: begin
					cfg_write(CFG_VALID_TICKS, 48'($urandom_range(1, 6)));
					cfg_write(CFG_PENDING_TICKS, 48'($urandom_range(1, 4)));
					cfg_write(CFG_RETRY_LIMIT, 48'($urandom_range(1, 15)));
				end
				1: begin
					cfg_write(CFG_VALID_TICKS, 48'hFFFF);
					cfg_write(CFG_PENDING_TICKS, 48'hFFFF);
					cfg_write(CFG_RETRY_LIMIT, 48'd15);
				end
				2: begin
					cfg_write(CFG_VALID_TICKS, 48'd0);
					cfg_write(CFG_PENDING_TICKS, 48'd0);
					cfg_write(CFG_RETRY_LIMIT, 48'd0);
				end
				default: begin
					cfg_write(CFG_VALID_TICKS, 48'($urandom_range(2, 12)));
					cfg_write(CFG_PENDING_TICKS, 48'($urandom_range(1, 3)));
					cfg_write(CFG_RETRY_LIMIT, 48'($urandom_range(1, 4)));
				end
			endcase
			cfg_write(CFG_MY_IP, {16'h0, $urandom});
			cfg_write(CFG_MY_MAC, 48'({$urandom, $urandom}));
			for (int k = 0; k < 4; k++) ip_pool[k] = $urandom;
			for (int i = 0; i < 50; i++)
				pending_words.push_back(($urandom_range(0, 2) == 0) ? tick_word() : rand_pkt());
			drain();
		end

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
